>>> sv/assert_macros.svh
// Assertion macros shared by the display list parser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks that a property holds at every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

>>> sv/dlcp_pkg.sv
// Package with the opcodes, codes, types and helpers of the display list parser.
`timescale 1ns / 1ps
`default_nettype none

package dlcp_pkg;

	localparam int MAX_LIST_BYTES_DEF = 65536;
	localparam int XF_DEPTH = 16;
	localparam int XF_IDX_W = $clog2(XF_DEPTH);
	localparam int NUM_STATS = 8;

	localparam logic [7:0] OP_NOP     = 8'h00;
	localparam logic [7:0] OP_CP      = 8'h08;
	localparam logic [7:0] OP_XF      = 8'h10;
	localparam logic [7:0] OP_IDX_A   = 8'h20;
	localparam logic [7:0] OP_IDX_B   = 8'h28;
	localparam logic [7:0] OP_IDX_C   = 8'h30;
	localparam logic [7:0] OP_IDX_D   = 8'h38;
	localparam logic [7:0] OP_SKIP    = 8'h40;
	localparam logic [7:0] OP_ONE     = 8'h48;
	localparam logic [7:0] OP_BP      = 8'h61;
	localparam logic [7:0] OP_PRIM_LO = 8'h80;
	localparam logic [7:0] OP_PRIM_HI = 8'hbf;

	localparam logic [2:0] SP_CP    = 3'd0;
	localparam logic [2:0] SP_XF    = 3'd1;
	localparam logic [2:0] SP_BP    = 3'd2;
	localparam logic [2:0] SP_IDX_A = 3'd3;

	localparam logic [2:0] IDX_GROUP_A = OP_IDX_A[5:3];

	localparam logic [2:0] ST_CMD    = 3'd0;
	localparam logic [2:0] ST_PARSED = 3'd1;
	localparam logic [2:0] ST_ERR    = 3'd2;
	localparam logic [2:0] ST_CP     = 3'd3;
	localparam logic [2:0] ST_XF     = 3'd4;
	localparam logic [2:0] ST_IDX    = 3'd5;
	localparam logic [2:0] ST_BP     = 3'd6;
	localparam logic [2:0] ST_PRIM   = 3'd7;

	typedef enum logic [1:0] {
		PH_OPCODE,
		PH_COLLECT,
		PH_XF_DATA,
		PH_SKIP
	} phase_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_REC,
		S_XF,
		S_STAT
	} ctrl_state_t;

	typedef enum logic [1:0] {
		OUT_REC,
		OUT_XF,
		OUT_STAT
	} out_sel_t;

	typedef struct packed {
		logic     accept;
		logic     load_out;
		out_sel_t sel;
		logic     mark_last;
		logic     idx_clr;
		logic     idx_inc;
		logic     clear_list;
	} ctrl_cmd_t;

	typedef struct packed {
		logic rec;
		logic xf;
		logic stats;
		logic idx_last_xf;
		logic idx_last_stat;
	} dp_status_t;

	// Number of operand bytes that follow an opcode, not counting XF data or primitive skip bytes.
	function automatic logic [3:0] bytes_needed(input logic [7:0] op);
		logic [3:0] n;
		n = 4'd0;
		if (op == OP_CP) begin
			n = 4'd5;
		end else if (op == OP_XF || op == OP_IDX_A || op == OP_IDX_B ||
				op == OP_IDX_C || op == OP_IDX_D || op == OP_BP) begin
			n = 4'd4;
		end else if (op == OP_SKIP) begin
			n = 4'd8;
		end else if (op >= OP_PRIM_LO && op <= OP_PRIM_HI) begin
			n = 4'd2;
		end
		return n;
	endfunction

endpackage

`default_nettype wire

>>> sv/dlcp_ctrl.sv
// Controller state machine that sequences byte acceptance and result emission.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dlcp_ctrl
	import dlcp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire dp_status_t status,
	output ctrl_cmd_t       cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_n;
	logic        out_valid_q;
	logic        stats_pend_q;
	logic        can_load;

	assign can_load  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					priority if (status.rec) begin
						state_n = S_REC;
					end else if (status.xf) begin
						state_n = S_XF;
					end else if (status.stats) begin
						state_n = S_STAT;
					end else begin
						state_n = S_IDLE;
					end
				end
			end
			S_REC: begin
				if (can_load) begin
					state_n = stats_pend_q ? S_STAT : S_IDLE;
				end
			end
			S_XF: begin
				if (can_load && status.idx_last_xf) begin
					state_n = stats_pend_q ? S_STAT : S_IDLE;
				end
			end
			S_STAT: begin
				if (can_load && status.idx_last_stat) begin
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.sel  = OUT_REC;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.accept  = in_valid;
				cmd.idx_clr = 1'b1;
			end
			S_REC: begin
				if (can_load) begin
					cmd.load_out  = 1'b1;
					cmd.sel       = OUT_REC;
					cmd.mark_last = !stats_pend_q;
				end
			end
			S_XF: begin
				if (can_load) begin
					cmd.load_out = 1'b1;
					cmd.sel      = OUT_XF;
					if (status.idx_last_xf) begin
						cmd.mark_last = !stats_pend_q;
						cmd.idx_clr   = 1'b1;
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end
			end
			S_STAT: begin
				if (can_load) begin
					cmd.load_out = 1'b1;
					cmd.sel      = OUT_STAT;
					if (status.idx_last_stat) begin
						cmd.mark_last  = 1'b1;
						cmd.clear_list = 1'b1;
						cmd.idx_clr    = 1'b1;
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			stats_pend_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.accept) begin
				stats_pend_q <= status.stats;
			end else if (cmd.clear_list) begin
				stats_pend_q <= 1'b0;
			end
		end
	end

	`ASSERT_NEVER(a_no_overwrite, clk, arst_n, cmd.load_out && out_valid_q && !out_ready, "result overwritten before its transaction completed")
	`ASSERT_AT(a_run_ends_marked, clk, arst_n, (state_q != S_IDLE && state_n == S_IDLE) |-> (cmd.load_out && cmd.mark_last), "run of results ended without a final mark")
	`ASSERT_AT(a_idle_no_pending, clk, arst_n, (state_q == S_IDLE) |-> !stats_pend_q, "statistics still pending while idle")

endmodule

`default_nettype wire

>>> sv/dlcp_datapath.sv
// Datapath with the parse state, XF word buffer, counters and output register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dlcp_datapath
	import dlcp_pkg::*;
#(
	parameter int MAX_LIST_BYTES = MAX_LIST_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ctrl_cmd_t   cmd,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output dp_status_t       status,
	output logic             kind,
	output logic [2:0]       load_space,
	output logic [15:0]      opcode_offset,
	output logic [15:0]      reg_address,
	output logic [4:0]       load_count,
	output logic [31:0]      value,
	output logic             last_of_run
);

	localparam int CNT_W = $clog2(MAX_LIST_BYTES + 1);
	localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_LIST_BYTES);
	localparam logic [2:0] LAST_STAT = 3'(NUM_STATS - 1);

	phase_t            phase_q, phase_n;
	logic [7:0]        opcode_q, opcode_n;
	logic [6:0]        bidx_q, bidx_n;
	logic [31:0]       word_q, word_n;
	logic [7:0]        short_q, short_n;
	logic [15:0]       xf_base_q, xf_base_n;
	logic [4:0]        xf_words_q, xf_words_n;
	logic [CNT_W-1:0]  pos_q, pos_n;
	logic [15:0]       cmd_start_q, cmd_start_n;
	logic [15:0]       skip_q, skip_n;
	logic              halted_q, halted_n;
	logic [CNT_W-1:0]  stat_q [NUM_STATS];
	logic [NUM_STATS-1:0] bump;

	logic [31:0]       xf_buf [XF_DEPTH];
	logic              xf_wr;
	logic [31:0]       asm_word;
	logic [3:0]        need;

	logic              rec_ev, xf_ev;
	logic [2:0]        rec_space_n, rec_space_q;
	logic [15:0]       rec_addr_n, rec_addr_q;
	logic [4:0]        rec_count_n, rec_count_q;
	logic [31:0]       rec_value_n, rec_value_q;

	logic [XF_IDX_W-1:0] emit_idx_q;
	logic [CNT_W-1:0]  stat_sel;

	assign asm_word = {word_q[23:0], data_byte};
	assign need     = bytes_needed(opcode_q);

	always_comb begin
		phase_n     = phase_q;
		opcode_n    = opcode_q;
		bidx_n      = bidx_q;
		word_n      = word_q;
		short_n     = short_q;
		xf_base_n   = xf_base_q;
		xf_words_n  = xf_words_q;
		pos_n       = pos_q;
		cmd_start_n = cmd_start_q;
		skip_n      = skip_q;
		halted_n    = halted_q;
		bump        = '0;
		xf_wr       = 1'b0;
		rec_ev      = 1'b0;
		xf_ev       = 1'b0;
		rec_space_n = SP_CP;
		rec_addr_n  = {8'h00, short_q};
		rec_count_n = 5'd1;
		rec_value_n = asm_word;

		if (pos_q < MAX_C) begin
			pos_n = pos_q + 1'b1;
		end

		if (!halted_q) begin
			unique case (phase_q)
				PH_OPCODE: begin
					cmd_start_n = 16'(pos_q);
					opcode_n    = data_byte;
					bidx_n      = '0;
					word_n      = '0;
					if (data_byte == OP_NOP || data_byte == OP_ONE) begin
						bump[ST_CMD] = 1'b1;
					end else if (bytes_needed(data_byte) != 4'd0) begin
						phase_n = PH_COLLECT;
					end else begin
						bump[ST_CMD] = 1'b1;
						bump[ST_ERR] = 1'b1;
						halted_n     = 1'b1;
					end
				end
				PH_COLLECT: begin
					if (bidx_q == 7'd0 && (opcode_q == OP_CP || opcode_q == OP_BP)) begin
						short_n = data_byte;
					end else begin
						word_n = asm_word;
					end
					bidx_n = bidx_q + 7'd1;
					if (bidx_n >= {3'b000, need}) begin
						phase_n = PH_OPCODE;
						priority if (opcode_q == OP_CP) begin
							rec_ev         = 1'b1;
							rec_value_n    = word_n;
							bump[ST_CMD]   = 1'b1;
							bump[ST_CP]    = 1'b1;
						end else if (opcode_q == OP_XF) begin
							xf_base_n  = word_n[15:0];
							xf_words_n = {1'b0, word_n[19:16]} + 5'd1;
							bidx_n     = '0;
							word_n     = '0;
							phase_n    = PH_XF_DATA;
						end else if (opcode_q == OP_IDX_A || opcode_q == OP_IDX_B ||
								opcode_q == OP_IDX_C || opcode_q == OP_IDX_D) begin
							rec_ev       = 1'b1;
							rec_space_n  = SP_IDX_A + (opcode_q[5:3] - IDX_GROUP_A);
							rec_addr_n   = {4'h0, word_n[11:0]};
							rec_count_n  = {1'b0, word_n[15:12]} + 5'd1;
							rec_value_n  = word_n;
							bump[ST_CMD] = 1'b1;
							bump[ST_IDX] = 1'b1;
						end else if (opcode_q == OP_SKIP) begin
							bump[ST_CMD] = 1'b1;
						end else if (opcode_q == OP_BP) begin
							rec_ev       = 1'b1;
							rec_space_n  = SP_BP;
							rec_value_n  = {8'h00, word_n[23:0]};
							bump[ST_CMD] = 1'b1;
							bump[ST_BP]  = 1'b1;
						end else begin
							skip_n        = word_n[15:0];
							bump[ST_CMD]  = 1'b1;
							bump[ST_PRIM] = 1'b1;
							if (word_n[15:0] != 16'd0) begin
								phase_n = PH_SKIP;
							end
						end
					end
				end
				PH_XF_DATA: begin
					word_n = asm_word;
					if (bidx_q[1:0] == 2'd3) begin
						xf_wr  = 1'b1;
						word_n = '0;
					end
					bidx_n = bidx_q + 7'd1;
					if (bidx_n >= {xf_words_q, 2'b00}) begin
						xf_ev        = 1'b1;
						bump[ST_CMD] = 1'b1;
						bump[ST_XF]  = 1'b1;
						phase_n      = PH_OPCODE;
					end
				end
				PH_SKIP: begin
					if (skip_q != 16'd0) begin
						skip_n = skip_q - 16'd1;
					end
					if (skip_n == 16'd0) begin
						phase_n = PH_OPCODE;
					end
				end
				default: begin
					phase_n = PH_OPCODE;
				end
			endcase
		end

		if (last_byte && !halted_n && (phase_n == PH_COLLECT || phase_n == PH_XF_DATA)) begin
			bump[ST_ERR] = 1'b1;
		end
	end

	always_comb begin
		status.rec           = rec_ev;
		status.xf            = xf_ev;
		status.stats         = last_byte;
		status.idx_last_xf   = (5'(emit_idx_q) == xf_words_q - 5'd1);
		status.idx_last_stat = (emit_idx_q[2:0] == LAST_STAT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_OPCODE;
			opcode_q    <= '0;
			bidx_q      <= '0;
			word_q      <= '0;
			short_q     <= '0;
			xf_base_q   <= '0;
			xf_words_q  <= '0;
			pos_q       <= '0;
			cmd_start_q <= '0;
			skip_q      <= '0;
			halted_q    <= 1'b0;
			for (int k = 0; k < NUM_STATS; k++) begin
				stat_q[k] <= '0;
			end
		end else if (cmd.accept) begin
			phase_q     <= phase_n;
			opcode_q    <= opcode_n;
			bidx_q      <= bidx_n;
			word_q      <= word_n;
			short_q     <= short_n;
			xf_base_q   <= xf_base_n;
			xf_words_q  <= xf_words_n;
			pos_q       <= pos_n;
			cmd_start_q <= cmd_start_n;
			skip_q      <= skip_n;
			halted_q    <= halted_n;
			for (int k = 0; k < NUM_STATS; k++) begin
				if (bump[k] && stat_q[k] < MAX_C) begin
					stat_q[k] <= stat_q[k] + 1'b1;
				end
			end
		end else if (cmd.clear_list) begin
			phase_q     <= PH_OPCODE;
			opcode_q    <= '0;
			bidx_q      <= '0;
			word_q      <= '0;
			short_q     <= '0;
			xf_base_q   <= '0;
			xf_words_q  <= '0;
			pos_q       <= '0;
			cmd_start_q <= '0;
			skip_q      <= '0;
			halted_q    <= 1'b0;
			for (int k = 0; k < NUM_STATS; k++) begin
				stat_q[k] <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && xf_wr) begin
			xf_buf[bidx_q[5:2]] <= asm_word;
		end
		if (cmd.accept && rec_ev) begin
			rec_space_q <= rec_space_n;
			rec_addr_q  <= rec_addr_n;
			rec_count_q <= rec_count_n;
			rec_value_q <= rec_value_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_idx_q <= '0;
		end else if (cmd.idx_clr) begin
			emit_idx_q <= '0;
		end else if (cmd.idx_inc) begin
			emit_idx_q <= emit_idx_q + 1'b1;
		end
	end

	// The parsed-byte statistic is the list position itself.
	assign stat_sel = (emit_idx_q[2:0] == ST_PARSED) ? pos_q : stat_q[emit_idx_q[2:0]];

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			last_of_run <= cmd.mark_last;
			unique case (cmd.sel)
				OUT_REC: begin
					kind          <= 1'b0;
					load_space    <= rec_space_q;
					opcode_offset <= cmd_start_q;
					reg_address   <= rec_addr_q;
					load_count    <= rec_count_q;
					value         <= rec_value_q;
				end
				OUT_XF: begin
					kind          <= 1'b0;
					load_space    <= SP_XF;
					opcode_offset <= cmd_start_q;
					reg_address   <= xf_base_q + 16'(emit_idx_q);
					load_count    <= xf_words_q;
					value         <= xf_buf[emit_idx_q];
				end
				OUT_STAT: begin
					kind          <= 1'b1;
					load_space    <= SP_CP;
					opcode_offset <= 16'd0;
					reg_address   <= 16'(emit_idx_q);
					load_count    <= 5'd0;
					value         <= {{(32-CNT_W){1'b0}}, stat_sel};
				end
				default: begin
					kind <= 1'b0;
				end
			endcase
		end
	end

	`ASSERT_AT(a_xf_idx_range, clk, arst_n, (cmd.load_out && cmd.sel == OUT_XF) |-> (5'(emit_idx_q) < xf_words_q), "XF record read beyond the buffered words")
	`ASSERT_AT(a_halt_holds, clk, arst_n, (halted_q && !cmd.clear_list) |=> halted_q, "parser left the halted state before the list ended")
	`ASSERT_AT(a_pos_bounded, clk, arst_n, pos_q <= MAX_C, "list position beyond its limit")

endmodule

`default_nettype wire

>>> sv/display_list_command_parser.sv
// Top level of the display list command parser.
`timescale 1ns / 1ps
`default_nettype none

// Takes a display list one byte per transaction and emits one record per register
// load and eight statistics when the byte marked last arrives. Bytes that cause
// no result stream at one per cycle. A byte that causes n results holds off the
// next byte while the controller steps them through the single output register,
// one per cycle when out_ready is high: one for a CP, BP or indexed load, N for
// the last byte of an XF load with N words, and eight more for the statistics at
// the end of a list. The next byte is taken while the final result still waits
// in the output register.
module display_list_command_parser
	import dlcp_pkg::*;
#(
	parameter int MAX_LIST_BYTES = MAX_LIST_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             kind,
	output logic [2:0]       load_space,
	output logic [15:0]      opcode_offset,
	output logic [15:0]      reg_address,
	output logic [4:0]       load_count,
	output logic [31:0]      value,
	output logic             last_of_run
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	dlcp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	dlcp_datapath #(
		.MAX_LIST_BYTES (MAX_LIST_BYTES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.status        (status),
		.kind          (kind),
		.load_space    (load_space),
		.opcode_offset (opcode_offset),
		.reg_address   (reg_address),
		.load_count    (load_count),
		.value         (value),
		.last_of_run   (last_of_run)
	);

endmodule

`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for the display list command parser.
`timescale 1ns / 1ps

module tb
	import dlcp_pkg::*;
();

	typedef struct packed {
		logic        kind;
		logic [2:0]  space;
		logic [15:0] offset;
		logic [15:0] address;
		logic [4:0]  count;
		logic [31:0] value;
		logic        last;
	} load_rec_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic        typed;
		logic [16:0] errors;
		logic [16:0] length;
	} dir_row_t;

	localparam dir_row_t DIRECTED [30] = '{
		'{8'h00, 1'b0, 1'b0, 17'd0, 17'd0},
		'{8'h48, 1'b0, 1'b0, 17'd0, 17'd0},
		'{8'h08, 1'b0, 1'b0, 17'd0, 17'd0},
		'{8'hff, 1'b0, 1'b0, 17'd0, 17'd0},
		'{8'hff, 1'b0, 1'b0, 17'd0, 17'd0},
		'{8'hff, 1'b0, 1'b0, 17'd0, 17'd0},
		'{8'hff, 1'b0, 1'b0, 17'd0, 17'd0},
		'{8'hff, 1'b0, 1'b0, 17'd0, 17'd0},
		'{8'h61, 1'b0, 1'b0, 17'd0, 17'd0},
		'{8'h00, 1'b0, 1'b0, 17'd0, 17'd0},
		'{8'hff, 1'b0, 1'b0, 17'd0, 17'd0},
		'{8'hff, 1'b0, 1'b0, 17'd0, 17'd0},
		'{8'hff, 1'b0, 1'b0, 17'd0, 17'd0},
		'{8'h38, 1'b0, 1'b0, 17'd0, 17'd0},
		'{8'hff, 1'b0, 1'b0, 17'd0, 17'd0},
		'{8'hff, 1'b0, 1'b0, 17'd0, 17'd0},
		'{8'hff, 1'b0, 1'b0, 17'd0, 17'd0},
		'{8'hff, 1'b1, 1'b1, 17'd0, 17'd18},
		'{8'h01, 1'b0, 1'b0, 17'd0, 17'd0},
		'{8'hff, 1'b1, 1'b1, 17'd1, 17'd2},
		'{8'h10, 1'b0, 1'b0, 17'd0, 17'd0},
		'{8'h00, 1'b0, 1'b0, 17'd0, 17'd0},
		'{8'h00, 1'b0, 1'b0, 17'd0, 17'd0},
		'{8'hff, 1'b0, 1'b0, 17'd0, 17'd0},
		'{8'hff, 1'b0, 1'b0, 17'd0, 17'd0},
		'{8'h12, 1'b1, 1'b1, 17'd1, 17'd6},
		'{8'h80, 1'b0, 1'b0, 17'd0, 17'd0},
		'{8'h00, 1'b0, 1'b0, 17'd0, 17'd0},
		'{8'h05, 1'b0, 1'b0, 17'd0, 17'd0},
		'{8'h11, 1'b1, 1'b1, 17'd0, 17'd4}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_ready;
	logic        kind;
	logic [2:0]  load_space;
	logic [15:0] opcode_offset;
	logic [15:0] reg_address;
	logic [4:0]  load_count;
	logic [31:0] value;
	logic        last_of_run;

	phase_t      prs_phase;
	logic [7:0]  prs_opcode;
	logic [6:0]  prs_index;
	logic [31:0] prs_word;
	logic [7:0]  prs_short;
	logic [15:0] prs_xf_base;
	logic [4:0]  prs_xf_words;
	logic [31:0] prs_xf_buf [XF_DEPTH];
	logic [16:0] prs_position;
	logic [15:0] prs_cmd_start;
	logic [15:0] prs_skip;
	logic        prs_halted;
	logic [16:0] prs_stats [NUM_STATS];

	load_rec_t   pending_loads [$];
	logic [7:0]  list_bytes [$];
	int          mismatch_count = 0;
	int          bytes_sent = 0;
	int          send_idle = 0;
	int          recv_idle = 0;

	display_list_command_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.load_space(load_space),
		.opcode_offset(opcode_offset),
		.reg_address(reg_address),
		.load_count(load_count),
		.value(value),
		.last_of_run(last_of_run)
	);

	function automatic int operand_bytes(input logic [7:0] op);
		case (op)
			OP_CP: return 5;
			OP_XF, OP_IDX_A, OP_IDX_B, OP_IDX_C, OP_IDX_D, OP_BP: return 4;
			OP_SKIP: return 8;
			default: return (op >= OP_PRIM_LO && op <= OP_PRIM_HI) ? 2 : 0;
		endcase
	endfunction

	function automatic void clear_parser();
		prs_phase = PH_OPCODE;
		prs_opcode = '0;
		prs_index = '0;
		prs_word = '0;
		prs_short = '0;
		prs_xf_base = '0;
		prs_xf_words = '0;
		prs_position = '0;
		prs_cmd_start = '0;
		prs_skip = '0;
		prs_halted = 1'b0;
		foreach (prs_xf_buf[i]) prs_xf_buf[i] = '0;
		foreach (prs_stats[i]) prs_stats[i] = '0;
	endfunction

	function automatic void bump_stat(input logic [2:0] which);
		if (prs_stats[which] < MAX_LIST_BYTES_DEF)
			prs_stats[which]++;
	endfunction

	function automatic void add_load(input logic k, input logic [2:0] sp,
			input logic [15:0] off, input logic [15:0] addr, input logic [4:0] cnt,
			input logic [31:0] val);
		load_rec_t r;
		r = '{k, sp, off, addr, cnt, val, 1'b0};
		pending_loads.insert(pending_loads.size(), r);
	endfunction

	function automatic void complete_command();
		prs_phase = PH_OPCODE;
		case (prs_opcode)
			OP_CP: begin
				add_load(1'b0, SP_CP, prs_cmd_start, {8'h00, prs_short}, 5'd1, prs_word);
				bump_stat(ST_CMD);
				bump_stat(ST_CP);
			end
			OP_XF: begin
				prs_xf_base = prs_word[15:0];
				prs_xf_words = {1'b0, prs_word[19:16]} + 5'd1;
				prs_index = '0;
				prs_word = '0;
				prs_phase = PH_XF_DATA;
			end
			OP_IDX_A, OP_IDX_B, OP_IDX_C, OP_IDX_D: begin
				add_load(1'b0, SP_IDX_A + (prs_opcode[5:3] - IDX_GROUP_A), prs_cmd_start,
					{4'h0, prs_word[11:0]}, {1'b0, prs_word[15:12]} + 5'd1, prs_word);
				bump_stat(ST_CMD);
				bump_stat(ST_IDX);
			end
			OP_SKIP: begin
				bump_stat(ST_CMD);
			end
			OP_BP: begin
				add_load(1'b0, SP_BP, prs_cmd_start, {8'h00, prs_short}, 5'd1,
					{8'h00, prs_word[23:0]});
				bump_stat(ST_CMD);
				bump_stat(ST_BP);
			end
			default: begin
				prs_skip = prs_word[15:0];
				bump_stat(ST_CMD);
				bump_stat(ST_PRIM);
				if (prs_skip != 0)
					prs_phase = PH_SKIP;
			end
		endcase
	endfunction

	function automatic void predict_parse(input logic [7:0] b, input logic l);
		int first = pending_loads.size();
		logic [16:0] pos = prs_position;
		if (prs_position < MAX_LIST_BYTES_DEF)
			prs_position++;
		if (!prs_halted) begin
			case (prs_phase)
				PH_OPCODE: begin
					prs_cmd_start = pos[15:0];
					prs_opcode = b;
					prs_index = '0;
					prs_word = '0;
					if (b == OP_NOP || b == OP_ONE) begin
						bump_stat(ST_CMD);
					end else if (operand_bytes(b) != 0) begin
						prs_phase = PH_COLLECT;
					end else begin
						bump_stat(ST_CMD);
						bump_stat(ST_ERR);
						prs_halted = 1'b1;
					end
				end
				PH_COLLECT: begin
					if (prs_index == 0 && (prs_opcode == OP_CP || prs_opcode == OP_BP))
						prs_short = b;
					else
						prs_word = {prs_word[23:0], b};
					prs_index++;
					if (prs_index >= operand_bytes(prs_opcode))
						complete_command();
				end
				PH_XF_DATA: begin
					prs_word = {prs_word[23:0], b};
					if (prs_index[1:0] == 2'd3) begin
						prs_xf_buf[prs_index[5:2]] = prs_word;
						prs_word = '0;
					end
					prs_index++;
					if (prs_index >= prs_xf_words * 4) begin
						for (int i = 0; i < prs_xf_words; i++)
							add_load(1'b0, SP_XF, prs_cmd_start, prs_xf_base + 16'(i),
								prs_xf_words, prs_xf_buf[i]);
						bump_stat(ST_CMD);
						bump_stat(ST_XF);
						prs_phase = PH_OPCODE;
					end
				end
				default: begin
					if (prs_skip > 0)
						prs_skip--;
					if (prs_skip == 0)
						prs_phase = PH_OPCODE;
				end
			endcase
		end
		if (l) begin
			if (!prs_halted && (prs_phase == PH_COLLECT || prs_phase == PH_XF_DATA))
				bump_stat(ST_ERR);
			prs_stats[ST_PARSED] = prs_position;
			for (int i = 0; i < NUM_STATS; i++)
				add_load(1'b1, 3'd0, 16'd0, 16'(i), 5'd0, {15'd0, prs_stats[i]});
			clear_parser();
		end
		if (pending_loads.size() > first)
			pending_loads[pending_loads.size() - 1].last = 1'b1;
	endfunction

	function automatic void queue_byte(input logic [7:0] b);
		list_bytes.insert(list_bytes.size(), b);
	endfunction

	function automatic void add_random(input int count);
		repeat (count) queue_byte(8'($urandom_range(255)));
	endfunction

	function automatic void append_command();
		int pick = $urandom_range(99);
		int n;
		logic [7:0] b;
		logic [15:0] base;
		if (pick < 6) begin
			queue_byte(OP_NOP);
		end else if (pick < 10) begin
			queue_byte(OP_ONE);
		end else if (pick < 22) begin
			queue_byte(OP_CP);
			add_random(5);
		end else if (pick < 38) begin
			n = ($urandom_range(9) == 0) ? 15 : $urandom_range(3);
			base = ($urandom_range(3) == 0) ? 16'hffff - 16'($urandom_range(3)) :
				16'($urandom_range(16'hffff));
			queue_byte(OP_XF);
			add_random(1);
			queue_byte({4'($urandom_range(15)), 4'(n)});
			queue_byte(base[15:8]);
			queue_byte(base[7:0]);
			add_random(4 * (n + 1));
		end else if (pick < 58) begin
			case ($urandom_range(3))
				0: queue_byte(OP_IDX_A);
				1: queue_byte(OP_IDX_B);
				2: queue_byte(OP_IDX_C);
				default: queue_byte(OP_IDX_D);
			endcase
			add_random(4);
		end else if (pick < 66) begin
			queue_byte(OP_SKIP);
			add_random(8);
		end else if (pick < 78) begin
			queue_byte(OP_BP);
			add_random(4);
		end else if (pick < 94) begin
			n = ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 6);
			queue_byte(8'($urandom_range(OP_PRIM_LO, OP_PRIM_HI)));
			queue_byte(8'h00);
			queue_byte(8'(n));
			add_random(n);
		end else begin
			do
				b = 8'($urandom_range(255));
			while (operand_bytes(b) != 0 || b == OP_NOP || b == OP_ONE);
			queue_byte(b);
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic l);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= l;
		do
			@(posedge clk);
		while (!in_ready);
		bytes_sent++;
		predict_parse(b, l);
	endtask

	task automatic send_random_list();
		int cut;
		list_bytes.delete();
		if ($urandom_range(9) == 0) begin
			add_random($urandom_range(1, 8));
		end else begin
			repeat ($urandom_range(1, 6)) append_command();
			if ($urandom_range(7) == 0) begin
				cut = $urandom_range(1, list_bytes.size());
				while (list_bytes.size() > cut)
					void'(list_bytes.pop_back());
			end
		end
		foreach (list_bytes[i])
			send_byte(list_bytes[i], i == list_bytes.size() - 1);
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin : result_check
		load_rec_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_loads.size() == 0) begin
				$error("Result arrived with no expectation waiting.");
				mismatch_count++;
			end else begin
				want = pending_loads.pop_front();
				check_field("kind", want.kind, kind);
				check_field("load_space", want.space, load_space);
				check_field("opcode_offset", want.offset, opcode_offset);
				check_field("reg_address", want.address, reg_address);
				check_field("load_count", want.count, load_count);
				check_field("value", want.value, value);
				check_field("last_of_run", want.last, last_of_run);
			end
		end
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		int base;
		in_valid = 1'b0;
		data_byte = 8'h00;
		last_byte = 1'b0;
		arst_n = 1'b0;
		clear_parser();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle = 20;
		recv_idle = 53;
		foreach (DIRECTED[r]) begin
			send_byte(DIRECTED[r].data, DIRECTED[r].last);
			if (DIRECTED[r].typed) begin
				base = pending_loads.size() - NUM_STATS;
				pending_loads[base + ST_ERR].value = {15'd0, DIRECTED[r].errors};
				pending_loads[base + ST_PARSED].value = {15'd0, DIRECTED[r].length};
			end
		end
		while (bytes_sent < 90)
			send_random_list();

		send_idle = 53;
		recv_idle = 20;
		while (bytes_sent < 150)
			send_random_list();

		send_idle = 0;
		recv_idle = 0;
		while (bytes_sent < 205)
			send_random_list();

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_loads.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
